[src/sgoq_pkg.sv]
package sgoq_pkg;

   // Fixed-point format of the position
   localparam int FRACTION_BITS = 8;
   localparam int SCALE_UNITS   = 1 << FRACTION_BITS;
   localparam int HALF_SCALE    = SCALE_UNITS / 2;

   // Phase count register
   localparam int MAX_PHASES     = 16;
   localparam int PHASE_CNT_W    = 5;
   localparam int DEFAULT_PHASES = 3;

   // Stored state
   localparam int ACCUM_BITS = 48;
   localparam int RESID_W    = 16;

   // Transaction fields
   localparam int ACTION_W = 2;
   localparam int AMOUNT_W = 32;
   localparam int PX_W     = 40;
   localparam int PH_W     = 4;

   // Datapath widths: position = accumulator plus residual, then times phase count
   localparam int POS_W  = ACCUM_BITS + 2;
   localparam int NUM_W  = POS_W + PHASE_CNT_W;
   localparam int MAG_W  = NUM_W - FRACTION_BITS;
   localparam int DIVD_W = MAG_W + FRACTION_BITS;
   localparam int REM_W  = $clog2(MAX_PHASES);
   localparam int CNT_W  = $clog2(DIVD_W + 1);

   typedef enum logic [ACTION_W-1:0] {
      ACT_ADVANCE = 2'd0,
      ACT_ORIGIN  = 2'd1,
      ACT_RESET   = 2'd2,
      ACT_QUERY   = 2'd3
   } action_type;

   typedef struct packed {
      logic                  done;
      logic [DIVD_W-1:0]     quotient;
      logic [REM_W-1:0]      remainder;
   } div_rsp_type;

endpackage

[src/sgoq_req_if.sv]
interface sgoq_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [sgoq_pkg::ACTION_W-1:0]         action;
   logic signed [sgoq_pkg::AMOUNT_W-1:0]  amount;

   modport source (output valid, output action, output amount, input ready);
   modport sink (input valid, input action, input amount, output ready);
endinterface

[src/sgoq_rsp_if.sv]
interface sgoq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          status;
   logic [sgoq_pkg::PX_W-1:0]     pixel_x;
   logic [sgoq_pkg::PH_W-1:0]     phase;

   modport source (output valid, output status, output pixel_x, output phase, input ready);
   modport sink (input valid, input status, input pixel_x, input phase, output ready);
endinterface

[src/subpixel_glyph_origin_quantizer.sv]
// Subpixel glyph origin quantizer.
//
// Keeps a text position in 1/256-pixel units plus a signed rounding residual.
// Each transaction on req (action, amount) yields exactly one transaction on
// rsp (status, pixel_x, phase). Advance adds a non-negative amount, saturating
// at the accumulator maximum; a negative amount returns status 1. Origin
// rounds position plus residual to the nearest of phase_count phases, returns
// the pixel and the phase and keeps the new residual. Reset line clears the
// position and residual. Query quantizes amount without touching the state.
// csr_we / csr_wdata write phase_count; values of 0 or above 16 are dropped.
//
// Advance and reset line go from accept straight to the finish state.
// Origin and query first pass the multiply, magnitude, divide and fix-up states; the
// restoring divider by phase_count retires one quotient bit per cycle over 55 bits.
// req.ready is high only while the sequencer is idle, so a new transaction is
// taken only after the previous one has left the finish state.
// A finished result waits in the rsp output register; the next transaction
// may be accepted meanwhile, and its result is held back until rsp drains.
// Synchronous reset returns the block to idle, clears position and residual
// and sets phase_count to 3.
module subpixel_glyph_origin_quantizer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [sgoq_pkg::PHASE_CNT_W-1:0]   csr_wdata,
   sgoq_req_if.sink                           req,
   sgoq_rsp_if.source                         rsp
);
   import sgoq_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ABS,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_FIX,
      ST_FINISH
   } state_type;

   state_type                   state_ff, state_in;

   // Architectural state
   logic [ACCUM_BITS-1:0]       acc_ff, acc_in;
   logic signed [RESID_W-1:0]   resid_ff, resid_in;
   logic [PHASE_CNT_W-1:0]      phase_cnt_ff, phase_cnt_in;

   // Per-transaction working registers
   action_type                  act_ff, act_in;
   logic signed [AMOUNT_W-1:0]  amt_ff, amt_in;
   logic signed [POS_W-1:0]     pos_ff, pos_in;
   logic signed [NUM_W-1:0]     num_ff, num_in;
   logic                        neg_ff, neg_in;
   logic [MAG_W-1:0]            tmag_ff, tmag_in;
   logic [PX_W-1:0]             px_ff, px_in;
   logic [PH_W-1:0]             ph_ff, ph_in;
   logic [RESID_W-1:0]          resid_new_ff, resid_new_in;

   // Output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_status_ff, rsp_status_in;
   logic [PX_W-1:0]             rsp_px_ff, rsp_px_in;
   logic [PH_W-1:0]             rsp_ph_ff, rsp_ph_in;

   // Shared divider
   logic                        div_start;
   div_rsp_type                 div_rsp;

   // Combinational helpers
   action_type                  req_act;
   logic [NUM_W-1:0]            num_mag;
   logic [MAG_W-1:0]            quot;
   logic [MAG_W-1:0]            xq;
   logic                        rem_nz;
   logic [PHASE_CNT_W-1:0]      ph_wrap;
   logic [RESID_W-1:0]          scaled_lo;
   logic [ACCUM_BITS:0]         adv_sum;

   assign req_act   = action_type'(req.action);
   assign num_mag   = num_ff[NUM_W-1] ? NUM_W'(-num_ff) : NUM_W'(num_ff);
   assign quot      = div_rsp.quotient[DIVD_W-1:FRACTION_BITS];
   assign rem_nz    = (div_rsp.remainder != '0);
   // Floor division: for a negative total with a remainder, step down one pixel
   assign xq        = neg_ff ? (rem_nz ? ~quot : (~quot + 1'b1)) : quot;
   assign ph_wrap   = phase_cnt_ff - PHASE_CNT_W'(div_rsp.remainder);
   assign scaled_lo = neg_ff ? (~div_rsp.quotient[RESID_W-1:0] + 1'b1)
                             : div_rsp.quotient[RESID_W-1:0];
   assign adv_sum   = {1'b0, acc_ff}
                    + {{(ACCUM_BITS + 1 - AMOUNT_W){1'b0}}, amt_ff};

   always_comb begin
      state_in      = state_ff;
      acc_in        = acc_ff;
      resid_in      = resid_ff;
      phase_cnt_in  = phase_cnt_ff;
      act_in        = act_ff;
      amt_in        = amt_ff;
      pos_in        = pos_ff;
      num_in        = num_ff;
      neg_in        = neg_ff;
      tmag_in       = tmag_ff;
      px_in         = px_ff;
      ph_in         = ph_ff;
      resid_new_in  = resid_new_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_px_in     = rsp_px_ff;
      rsp_ph_in     = rsp_ph_ff;
      div_start     = 1'b0;

      // Drop out-of-range phase counts
      if (csr_we && (csr_wdata != '0) && (csr_wdata <= PHASE_CNT_W'(MAX_PHASES))) begin
         phase_cnt_in = csr_wdata;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               act_in = req_act;
               amt_in = req.amount;
               if (req_act == ACT_ORIGIN) begin
                  pos_in = POS_W'(acc_ff) + POS_W'(resid_ff);
               end else begin
                  pos_in = POS_W'(req.amount);
               end
               px_in = '0;
               ph_in = '0;
               if (req_act == ACT_ORIGIN || req_act == ACT_QUERY) begin
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_MUL: begin
            // Round to the nearest phase: pos * p + half a phase
            num_in = NUM_W'(pos_ff) * NUM_W'($signed({1'b0, phase_cnt_ff}))
                   + NUM_W'(HALF_SCALE);
            state_in = ST_ABS;
         end
         ST_ABS: begin
            // Truncating divide by the scale: shift the magnitude
            neg_in   = num_ff[NUM_W-1];
            tmag_in  = num_mag[NUM_W-1:FRACTION_BITS];
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            px_in        = xq[PX_W-1:0];
            ph_in        = (neg_ff && rem_nz) ? ph_wrap[PH_W-1:0] : div_rsp.remainder;
            resid_new_in = pos_ff[RESID_W-1:0] - scaled_lo;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            // Hold the result until the output register is free
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = 1'b0;
               rsp_px_in     = '0;
               rsp_ph_in     = '0;
               case (act_ff)
                  ACT_ADVANCE: begin
                     if (amt_ff[AMOUNT_W-1]) begin
                        rsp_status_in = 1'b1;
                     end else if (adv_sum[ACCUM_BITS]) begin
                        acc_in = '1;
                     end else begin
                        acc_in = adv_sum[ACCUM_BITS-1:0];
                     end
                  end
                  ACT_ORIGIN: begin
                     rsp_px_in = px_ff;
                     rsp_ph_in = ph_ff;
                     resid_in  = resid_new_ff;
                  end
                  ACT_RESET: begin
                     acc_in   = '0;
                     resid_in = '0;
                  end
                  ACT_QUERY: begin
                     rsp_ph_in = ph_ff;
                  end
                  default: begin
                     rsp_status_in = 1'b0;
                  end
               endcase
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         resid_ff     <= '0;
         phase_cnt_ff <= PHASE_CNT_W'(DEFAULT_PHASES);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         resid_ff     <= resid_in;
         phase_cnt_ff <= phase_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff        <= act_in;
      amt_ff        <= amt_in;
      pos_ff        <= pos_in;
      num_ff        <= num_in;
      neg_ff        <= neg_in;
      tmag_ff       <= tmag_in;
      px_ff         <= px_in;
      ph_ff         <= ph_in;
      resid_new_ff  <= resid_new_in;
      rsp_status_ff <= rsp_status_in;
      rsp_px_ff     <= rsp_px_in;
      rsp_ph_ff     <= rsp_ph_in;
   end

   // Divide |total| * 256 by the phase count; the integer part's remainder
   // is captured on the way
   sgoq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({tmag_ff, {FRACTION_BITS{1'b0}}}),
      .divisor  (phase_cnt_ff),
      .div_rsp  (div_rsp)
   );

   assign req.ready   = (state_ff == ST_IDLE);
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.status  = rsp_status_ff;
   assign rsp.pixel_x = rsp_px_ff;
   assign rsp.phase   = rsp_ph_ff;

endmodule

[src/sgoq_div.sv]
module sgoq_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [sgoq_pkg::DIVD_W-1:0]    dividend,
   input  logic [sgoq_pkg::PHASE_CNT_W-1:0] divisor,
   output sgoq_pkg::div_rsp_type          div_rsp
);
   import sgoq_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [DIVD_W-1:0]   dvd_ff, dvd_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [REM_W-1:0]    rmid_ff, rmid_in;

   logic [REM_W:0]      trial;
   logic                fits;
   logic [REM_W:0]      diff;

   // One restoring step: shift the next dividend bit into the partial remainder
   assign trial = {rem_ff, dvd_ff[DIVD_W-1]};
   assign fits  = (trial >= divisor);
   assign diff  = trial - divisor;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      rmid_in  = rmid_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         dvd_in   = dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
         dvd_in   = {dvd_ff[DIVD_W-2:0], fits};
         count_in = count_ff + 1'b1;
         // Remainder of the integer part, before the fraction bits come in
         if (count_ff == CNT_W'(MAG_W - 1)) begin
            rmid_in = rem_in;
         end
         if (count_ff == CNT_W'(DIVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      rmid_ff  <= rmid_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = dvd_ff;
   assign div_rsp.remainder = rmid_ff;

endmodule
